[rtl/spas_pkg.sv]
`default_nettype none
package spas_pkg;

  localparam int NODES  = 8;
  localparam int IDX_W  = $clog2(NODES);
  localparam int ADDR_W = $clog2(NODES * NODES);
  localparam int WGT_W  = 10;
  localparam int DIST_W = 16;

  localparam logic [WGT_W-1:0]  NO_EDGE  = WGT_W'(1000);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  typedef struct packed {
    logic             edge_wr;
    logic             init;
    logic             scan;
    logic             settle;
    logic             rd;
    logic             relax;
    logic             out_load;
    logic [IDX_W-1:0] cnt;
  } spas_cmd_t;

  typedef struct packed {
    logic best_found;
    logic out_free;
  } spas_sts_t;

endpackage
`default_nettype wire

[rtl/spas_ram.sv]
`default_nettype none
module spas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/spas_ctrl.sv]
`default_nettype none
module spas_ctrl
  import spas_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      operation_i,
  output logic           in_ready_o,
  input  wire spas_sts_t sts_i,
  output spas_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             last;
  logic             accept;

  assign last       = (cnt_q == IDX_W'(NODES - 1));
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.cnt = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_RUN) begin
            cmd_o.init = 1'b1;
            state_d    = ST_SCAN;
            cnt_d      = '0;
          end else begin
            cmd_o.edge_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (last) begin
          state_d = ST_CHK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CHK: begin
        cnt_d = '0;
        if (sts_i.best_found) begin
          cmd_o.settle = 1'b1;
          state_d      = ST_RD;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.relax = 1'b1;
        if (last) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end else begin
          state_d = ST_RD;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_scan_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && !last |=> (state_q == ST_SCAN))
    else $error("scan left early");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over a waiting item");

  a_rd_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> cmd_o.relax)
    else $error("weight read not followed by relax");

endmodule
`default_nettype wire

[rtl/spas_dp.sv]
`default_nettype none
module spas_dp
  import spas_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spas_cmd_t         cmd_i,
  output spas_sts_t              sts_o,
  input  wire logic [2:0]        row_node_i,
  input  wire logic [2:0]        col_node_i,
  input  wire logic [WGT_W-1:0]  edge_weight_i,
  input  wire logic [2:0]        source_node_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             node_index_o,
  output logic [DIST_W-1:0]      path_length_o,
  output logic [2:0]             previous_node_o,
  output logic                   reachable_o,
  output logic                   last_o
);

  logic [DIST_W-1:0] dist_q [NODES];
  logic [IDX_W-1:0]  pred_q [NODES];
  logic [NODES-1:0]  settled_q;
  logic [NODES-1:0]  reached_q;

  logic [NODES*NODES-1:0] wvld_q;
  logic                   rd_vld_q;
  logic                   found_q;
  logic [IDX_W-1:0]       best_q;
  logic [DIST_W-1:0]      best_dist_q;
  logic                   out_valid_q;

  logic [IDX_W-1:0]  src;
  logic              wr_ok;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WGT_W-1:0]  rdata, weight;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] nd;
  logic              cand, relax_hit;

  // Out-of-range source clamps to the top node
  assign src = (int'(source_node_i) >= NODES) ? IDX_W'(NODES - 1) : IDX_W'(source_node_i);
  assign wr_ok = cmd_i.edge_wr && (int'(row_node_i) < NODES) && (int'(col_node_i) < NODES);
  assign waddr = ADDR_W'(int'(row_node_i) * NODES + int'(col_node_i));
  assign raddr = ADDR_W'(int'(best_q) * NODES + int'(cmd_i.cnt));

  spas_ram #(
    .WIDTH(WGT_W),
    .DEPTH(NODES * NODES)
  ) u_wgt_ram (
    .clk_i  (clk_i),
    .we_i   (wr_ok),
    .waddr_i(waddr),
    .wdata_i(edge_weight_i),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Never-written entries read as no edge
  assign weight = rd_vld_q ? rdata : NO_EDGE;
  assign sum    = {1'b0, best_dist_q} + (DIST_W + 1)'(weight);
  assign nd     = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  assign cand = reached_q[cmd_i.cnt] && !settled_q[cmd_i.cnt] &&
                ((cmd_i.cnt == '0) || !found_q || (dist_q[cmd_i.cnt] < best_dist_q));

  assign relax_hit = cmd_i.relax && !settled_q[cmd_i.cnt] && (weight < NO_EDGE) &&
                     (!reached_q[cmd_i.cnt] || (nd < dist_q[cmd_i.cnt]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q      <= '0;
      rd_vld_q    <= 1'b0;
      settled_q   <= '0;
      reached_q   <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        wvld_q[waddr] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rd_vld_q <= wvld_q[raddr];
      end
      if (cmd_i.init) begin
        settled_q <= '0;
        reached_q <= {{(NODES-1){1'b0}}, 1'b1} << src;
      end
      if (cmd_i.scan) begin
        if (cmd_i.cnt == '0) begin
          found_q <= cand;
        end else if (cand) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.settle) begin
        settled_q[best_q] <= 1'b1;
      end
      if (relax_hit) begin
        reached_q[cmd_i.cnt] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      for (int i = 0; i < NODES; i++) begin
        dist_q[i] <= (IDX_W'(i) == src) ? '0 : DIST_MAX;
        pred_q[i] <= (IDX_W'(i) == src) ? src : '0;
      end
    end
    if (cmd_i.scan && cand) begin
      best_q      <= cmd_i.cnt;
      best_dist_q <= dist_q[cmd_i.cnt];
    end
    if (relax_hit) begin
      dist_q[cmd_i.cnt] <= nd;
      pred_q[cmd_i.cnt] <= best_q;
    end
    if (cmd_i.out_load) begin
      node_index_o    <= 3'(cmd_i.cnt);
      path_length_o   <= dist_q[cmd_i.cnt];
      previous_node_o <= 3'(pred_q[cmd_i.cnt]);
      reachable_o     <= reached_q[cmd_i.cnt];
      last_o          <= (cmd_i.cnt == IDX_W'(NODES - 1));
    end
  end

  assign sts_o.best_found = found_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;

  a_settle_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.settle |-> found_q && reached_q[best_q] && !settled_q[best_q])
    else $error("settling a node that is not a reached candidate");

  a_settle_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.settle |=> settled_q[$past(best_q)])
    else $error("settled flag not set");

endmodule
`default_nettype wire

[rtl/shortest_path_array_scan_core.sv]
// Channel  Handshake              Payload
// input    in_valid_i/in_ready_o  operation, row_node, col_node, edge_weight, source_node
// output   out_valid_o/out_ready_i node_index, path_length, previous_node, reachable, last
//
// An edge write is taken in the idle state; edge writes may arrive back to back.
// A run searches in rounds from the source (N = NODES):
// each round scans the distance array one node a cycle, then relaxes each neighbor
// in a read state and an update state, behind the registered weight RAM read.
// Then N results leave one per cycle, longer when out_ready_i is low.
// Reset clears the weight valid bits, so every edge reads as absent; no clearing pass.
// in_ready_o is low from the run item until its last result is loaded.
`default_nettype none
module shortest_path_array_scan_core
  import spas_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [2:0]        row_node_i,
  input  wire logic [2:0]        col_node_i,
  input  wire logic [WGT_W-1:0]  edge_weight_i,
  input  wire logic [2:0]        source_node_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             node_index_o,
  output logic [DIST_W-1:0]      path_length_o,
  output logic [2:0]             previous_node_o,
  output logic                   reachable_o,
  output logic                   last_o
);

  spas_cmd_t cmd;
  spas_sts_t sts;

  spas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .operation_i(operation_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spas_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .row_node_i     (row_node_i),
    .col_node_i     (col_node_i),
    .edge_weight_i  (edge_weight_i),
    .source_node_i  (source_node_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .node_index_o   (node_index_o),
    .path_length_o  (path_length_o),
    .previous_node_o(previous_node_o),
    .reachable_o    (reachable_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import spas_pkg::*;

  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int ITEMS_TARGET    = 200;
  localparam int SETTLE_CYCLES   = 20;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [2:0]        node;
    logic [DIST_W-1:0] plen;
    logic [2:0]        prev;
    logic              reach;
    logic              last;
  } node_result_t;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              op_r      = OP_WRITE;
  logic [2:0]        row_r     = '0;
  logic [2:0]        col_r     = '0;
  logic [WGT_W-1:0]  wgt_r     = '0;
  logic [2:0]        src_r     = '0;
  logic              out_ready = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [2:0]        node_index_o;
  logic [DIST_W-1:0] path_length_o;
  logic [2:0]        previous_node_o;
  logic              reachable_o;
  logic              last_o;

  logic [WGT_W-1:0] weight_mat [NODES][NODES];
  node_result_t     pending_results [$];
  node_result_t     got_r;
  node_result_t     want_r;

  int items_sent     = 0;
  int edge_writes    = 0;
  int path_runs      = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int tx_gap_pct     = 0;
  int rx_stall_pct   = 0;
  int rx_stall_left  = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  logic hold_req     = 1'b0;

  shortest_path_array_scan_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .operation_i    (op_r),
    .row_node_i     (row_r),
    .col_node_i     (col_r),
    .edge_weight_i  (wgt_r),
    .source_node_i  (src_r),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .node_index_o   (node_index_o),
    .path_length_o  (path_length_o),
    .previous_node_o(previous_node_o),
    .reachable_o    (reachable_o),
    .last_o         (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 15) return NO_EDGE;
    if (r < 20) return WGT_W'($urandom_range(1001, 1023));
    if (r < 25) return WGT_W'($urandom_range(900, 999));
    return WGT_W'($urandom_range(1, 20));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 30;
      default: return 70;
    endcase
  endfunction

  // Settle the closest unsettled node each round, lowest index on ties,
  // and queue one result per node.
  function automatic void shortest_paths(input int source);
    logic [DIST_W-1:0] dist_a [NODES];
    logic [2:0]        prev [NODES];
    bit                done [NODES];
    bit                seen [NODES];
    int                best;
    int unsigned       sum;
    node_result_t      r;
    if (source >= NODES) source = NODES - 1;
    for (int i = 0; i < NODES; i++) begin
      dist_a[i] = DIST_MAX;
      prev[i]   = '0;
      done[i]   = 1'b0;
      seen[i]   = 1'b0;
    end
    dist_a[source] = '0;
    prev[source]   = 3'(source);
    seen[source]   = 1'b1;
    for (int round = 0; round < NODES; round++) begin
      best = -1;
      for (int i = 0; i < NODES; i++) begin
        if (seen[i] && !done[i] && (best < 0 || dist_a[i] < dist_a[best])) best = i;
      end
      if (best < 0) break;
      done[best] = 1'b1;
      for (int v = 0; v < NODES; v++) begin
        if (!done[v] && weight_mat[best][v] < NO_EDGE) begin
          sum = int'(dist_a[best]) + int'(weight_mat[best][v]);
          if (sum > DIST_MAX) sum = DIST_MAX;
          if (!seen[v] || sum < dist_a[v]) begin
            dist_a[v] = DIST_W'(sum);
            prev[v]   = 3'(best);
            seen[v]   = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < NODES; i++) begin
      r.node  = 3'(i);
      r.plen  = seen[i] ? dist_a[i] : DIST_MAX;
      r.prev  = seen[i] ? prev[i] : 3'd0;
      r.reach = seen[i];
      r.last  = (i == NODES - 1);
      pending_results.push_back(r);
    end
  endfunction

  task automatic offer_item(input logic op, input logic [2:0] row, input logic [2:0] col,
                            input logic [WGT_W-1:0] w, input logic [2:0] src);
    int gap;
    in_valid <= 1'b1;
    op_r     <= op;
    row_r    <= row;
    col_r    <= col;
    wgt_r    <= w;
    src_r    <= src;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    if (op == OP_WRITE) begin
      weight_mat[row][col] = w;
      edge_writes++;
    end else begin
      shortest_paths(src);
      path_runs++;
    end
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_edge(input int row, input int col, input logic [WGT_W-1:0] w);
    offer_item(OP_WRITE, 3'(row), 3'(col), w, 3'($urandom_range(0, 7)));
  endtask

  // Row, column and weight ride along as noise on a run item.
  task automatic run_from(input int src);
    offer_item(OP_RUN, 3'($urandom), 3'($urandom), WGT_W'($urandom), 3'(src));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_empty_graph();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    run_from(0);
    run_from(7);
    wait_for_results();
  endtask

  task automatic test_edge_cases();
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    write_edge(0, 1, 0);
    write_edge(1, 2, 999);
    write_edge(0, 2, 999);   // equal length via node 1 keeps predecessor 0
    write_edge(2, 3, NO_EDGE);
    write_edge(2, 4, 1023);  // above the no-edge mark
    write_edge(3, 3, 5);
    write_edge(0, 6, 50);
    write_edge(1, 6, 10);    // strictly shorter, predecessor moves to 1
    write_edge(6, 7, 512);
    write_edge(7, 0, 1);
    write_edge(4, 5, 1);
    run_from(0);
    run_from(7);
    run_from(4);
    run_from(3);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b1;
    run_from(0);
    run_from(7);
    write_edge(5, 2, 3);
    run_from(5);
    run_from(2);
    wait_for_results();
  endtask

  task automatic test_random_graphs();
    int n_writes;
    int n_runs;
    int r;
    int c;
    logic [WGT_W-1:0] w;
    while (items_sent < ITEMS_TARGET) begin
      tx_gap_pct   = pick_pct();
      rx_stall_pct = pick_pct();
      if ($urandom_range(0, 9) == 0) begin
        // Cut a node's outgoing edges by dropping its whole row.
        r = $urandom_range(0, NODES - 1);
        for (c = 0; c < NODES; c++) write_edge(r, c, NO_EDGE);
      end else begin
        n_writes = $urandom_range(4, 14);
        repeat (n_writes) begin
          r = $urandom_range(0, NODES - 1);
          c = $urandom_range(0, NODES - 1);
          w = pick_weight();
          write_edge(r, c, w);
          if ($urandom_range(0, 1) == 1) write_edge(c, r, w);
        end
      end
      n_runs = $urandom_range(1, 3);
      repeat (n_runs) run_from($urandom_range(0, NODES - 1));
    end
    wait_for_results();
  endtask

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else begin
      rx_stall_left = pick_gap(rx_stall_pct);
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      results_seen++;
      got_r = '{node: node_index_o, plen: path_length_o, prev: previous_node_o,
                reach: reachable_o, last: last_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("tb: unexpected result node=%0d len=%0d prev=%0d reach=%0b last=%0b",
                   got_r.node, got_r.plen, got_r.prev, got_r.reach, got_r.last);
      end else begin
        want_r = pending_results.pop_front();
        if (got_r.node !== want_r.node || got_r.plen !== want_r.plen ||
            got_r.prev !== want_r.prev || got_r.reach !== want_r.reach ||
            got_r.last !== want_r.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("tb: mismatch expected node=%0d len=%0d prev=%0d reach=%0b last=%0b",
                     want_r.node, want_r.plen, want_r.prev, want_r.reach, want_r.last);
            $display("tb:          actual   node=%0d len=%0d prev=%0d reach=%0b last=%0b",
                     got_r.node, got_r.plen, got_r.prev, got_r.reach, got_r.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("tb: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_results.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < NODES; i++)
      for (int j = 0; j < NODES; j++) weight_mat[i][j] = NO_EDGE;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_graph();
    test_edge_cases();
    test_backpressure();
    test_random_graphs();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mismatches += pending_results.size();
    $display("tb: %0d edge writes and %0d runs sent, %0d node results checked",
             edge_writes, path_runs, results_seen);
    $display("tb: included empty graph, no-edge weights, ties, long output hold-off");
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
